/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; the tokenizer top level includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/csvt_pkg.sv */
// Types, character codes and helpers for the CSV tokenizer
package csvt_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CELL_EMPTY  = 3'd0,
    CELL_INT    = 3'd1,
    CELL_DEC    = 3'd2,
    CELL_TEXT   = 3'd3,
    CELL_HEADER = 3'd4
  } cell_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  localparam logic CMD_END = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [63:0] ACC_CAP = 64'h8000_0000_0000_0000;
  // floor(2^63 / 10)
  localparam logic [63:0] ACC_LIM = 64'd922337203685477580;

  typedef struct packed {
    phase_e      phase;
    logic        neg;
    logic [63:0] acc;
  } num_t;

  typedef struct packed {
    logic       in_quotes;
    logic       quote_pend;
    logic       skip_space;
    logic       field_started;
    logic       row_has_field;
    logic       forced_text;
    logic       has_digit;
    logic [1:0] sign_cnt;
    logic       point_seen;
    logic       in_header;
    num_t       num;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  content;
    cell_e       cell_type;
    logic        ends_row;
    logic [63:0] value;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* rtl/csvt_num.sv */
// Number scanner: sign, digits and saturating multiply-by-ten accumulate
module csvt_num (
  input  csvt_pkg::num_t     num_i,
  input  logic [7:0]         char_i,
  output csvt_pkg::num_t     num_o
);
  import csvt_pkg::*;

  logic [3:0]  digit;
  logic [63:0] thr;
  logic [63:0] acc_acc;

  assign digit = char_i[3:0];
  assign thr   = (digit == 4'd9) ? (ACC_LIM - 64'd1) : ACC_LIM;

  always_comb begin
    if (num_i.acc > thr) begin
      acc_acc = ACC_CAP;
    end else begin
      acc_acc = (num_i.acc << 3) + (num_i.acc << 1) + {60'd0, digit};
    end
  end

  always_comb begin
    num_o = num_i;
    case (num_i.phase)
      PH_LEAD: begin
        if (is_space(char_i)) begin
          num_o = num_i;
        end else if ((char_i == CH_PLUS) || (char_i == CH_MINUS)) begin
          num_o.neg   = (char_i == CH_MINUS);
          num_o.phase = PH_DIGITS;
        end else if (is_digit(char_i)) begin
          num_o.acc   = acc_acc;
          num_o.phase = PH_DIGITS;
        end else begin
          num_o.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit(char_i)) begin
          num_o.acc = acc_acc;
        end else begin
          num_o.phase = PH_DONE;
        end
      end
      default: num_o = num_i;
    endcase
  end

endmodule

/* rtl/csvt_step.sv */
// Per-beat tokenizer step: quoting, field and row ends, cell typing
module csvt_step (
  input  csvt_pkg::state_t   st_i,
  input  logic               frh_i,
  input  logic               cmd_i,
  input  logic [7:0]         char_i,
  output csvt_pkg::state_t   st_o,
  output logic               res_vld_o,
  output csvt_pkg::res_t     res_o
);
  import csvt_pkg::*;

  num_t        num_nx;
  cell_e       ctype;
  logic [63:0] value;
  logic        go;
  logic        end_req;
  logic        end_ends;

  function automatic state_t clear_field(input state_t s);
    state_t r;
    r               = s;
    r.in_quotes     = 1'b0;
    r.quote_pend    = 1'b0;
    r.field_started = 1'b0;
    r.forced_text   = 1'b0;
    r.has_digit     = 1'b0;
    r.sign_cnt      = 2'd0;
    r.point_seen    = 1'b0;
    r.num.phase     = PH_LEAD;
    r.num.neg       = 1'b0;
    r.num.acc       = 64'd0;
    return r;
  endfunction

  csvt_num u_num (
    .num_i  (st_i.num),
    .char_i (char_i),
    .num_o  (num_nx)
  );

  always_comb begin
    if (st_i.in_header) begin
      ctype = CELL_HEADER;
    end else if (!st_i.field_started) begin
      ctype = CELL_EMPTY;
    end else if (st_i.forced_text || (st_i.sign_cnt > 2'd1) || !st_i.has_digit) begin
      ctype = CELL_TEXT;
    end else if (st_i.point_seen) begin
      ctype = CELL_DEC;
    end else begin
      ctype = CELL_INT;
    end
  end

  always_comb begin
    if (ctype != CELL_INT) begin
      value = 64'd0;
    end else if (st_i.num.neg) begin
      value = 64'd0 - st_i.num.acc;
    end else if (st_i.num.acc[63]) begin
      value = ACC_CAP - 64'd1;
    end else begin
      value = st_i.num.acc;
    end
  end

  always_comb begin
    st_o      = st_i;
    res_o     = '0;
    res_vld_o = 1'b0;
    go        = 1'b1;
    end_req   = 1'b0;
    end_ends  = 1'b0;

    if (cmd_i == CMD_END) begin
      if (st_i.field_started || (st_i.in_header && st_i.row_has_field)) begin
        end_req  = 1'b1;
        end_ends = 1'b1;
      end else if (st_i.row_has_field) begin
        res_vld_o      = 1'b1;
        res_o.kind     = KIND_ROW;
        res_o.ends_row = 1'b1;
      end
      go = 1'b0;
    end else begin
      if (st_i.quote_pend) begin
        st_o.quote_pend = 1'b0;
        if (char_i == CH_QUOTE) begin
          // doubled quote: one literal quote
          st_o.num      = num_nx;
          res_vld_o     = 1'b1;
          res_o.kind    = KIND_BYTE;
          res_o.content = char_i;
          go            = 1'b0;
        end else begin
          st_o.in_quotes = ~st_i.in_quotes;
        end
      end else if (st_i.skip_space) begin
        if (is_space(char_i)) begin
          go = 1'b0;
        end else begin
          st_o.skip_space = 1'b0;
        end
      end

      if (go && !st_o.in_quotes) begin
        if (char_i == CH_COMMA) begin
          end_req = 1'b1;
          go      = 1'b0;
        end else if ((char_i == CH_LF) || (char_i == CH_CR)) begin
          if (st_i.field_started || st_i.in_header) begin
            end_req  = 1'b1;
            end_ends = 1'b1;
          end else begin
            res_vld_o          = 1'b1;
            res_o.kind         = KIND_ROW;
            res_o.ends_row     = 1'b1;
            st_o               = clear_field(st_o);
            st_o.row_has_field = 1'b0;
            st_o.skip_space    = 1'b1;
          end
          go = 1'b0;
        end
      end

      if (go) begin
        st_o.field_started = 1'b1;
        st_o.num           = num_nx;
        if (char_i == CH_QUOTE) begin
          st_o.quote_pend  = 1'b1;
          st_o.forced_text = 1'b1;
        end else begin
          if (is_digit(char_i)) begin
            st_o.has_digit = 1'b1;
          end else if (char_i == CH_POINT) begin
            st_o.point_seen = 1'b1;
          end else if ((char_i == CH_PLUS) || (char_i == CH_MINUS)) begin
            if (st_i.has_digit) begin
              st_o.forced_text = 1'b1;
            end else if (st_i.sign_cnt < 2'd2) begin
              st_o.sign_cnt = st_i.sign_cnt + 2'd1;
            end
          end else if (!is_space(char_i)) begin
            st_o.forced_text = 1'b1;
          end
          res_vld_o     = 1'b1;
          res_o.kind    = KIND_BYTE;
          res_o.content = char_i;
        end
      end
    end

    if (end_req) begin
      res_vld_o       = 1'b1;
      res_o.kind      = KIND_FIELD;
      res_o.cell_type = ctype;
      res_o.ends_row  = end_ends;
      res_o.value     = value;
      st_o            = clear_field(st_o);
      if (end_ends) begin
        st_o.row_has_field = 1'b0;
        st_o.in_header     = 1'b0;
        st_o.skip_space    = 1'b1;
      end else begin
        st_o.row_has_field = 1'b1;
      end
    end

    if (cmd_i == CMD_END) begin
      st_o               = clear_field(st_o);
      st_o.row_has_field = 1'b0;
      st_o.skip_space    = 1'b0;
      st_o.in_header     = frh_i;
    end
  end

endmodule

/* rtl/csv_field_tokenizer_typer.sv */
// CSV field tokenizer and typer: top level with beat registers and config
// Takes one byte (or an end-of-text command) per beat and sustains one beat
// per clock cycle while the output is not stalled. A beat is captured in the
// input register, worked through a single step stage (quote handling,
// field/row ends, typing, and one saturating multiply-by-ten accumulate) and
// lands in the result register, which drives the outputs. Beats that give no
// result (an opening quote, skipped whitespace, a quiet end of text) still
// pass through the step stage. The header-row register is written only when
// the input register is empty (cfg_ready_o low otherwise); a write also
// reloads the header-row flag of the current text at once.
module csv_field_tokenizer_typer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        first_row_is_header_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  content_byte_o,
  output logic [2:0]  cell_type_o,
  output logic        ends_row_o,
  output logic signed [63:0] integer_value_o
);
  import csvt_pkg::*;
  `include "assert_macros.svh"

  logic       frh_q;
  logic       item_vld_q, item_vld_d;
  logic       cmd_q;
  logic [7:0] char_q;
  state_t     st_q, st_d;
  logic       out_vld_q, out_vld_d;
  res_t       res_q, res_d;
  logic       res_vld;
  logic       out_free;
  logic       fire;
  logic       in_acc;
  logic       cfg_wr;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign fire        = item_vld_q && out_free;
  assign in_stall_o  = item_vld_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !item_vld_q;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  csvt_step u_step (
    .st_i      (st_q),
    .frh_i     (frh_q),
    .cmd_i     (cmd_q),
    .char_i    (char_q),
    .st_o      (st_d),
    .res_vld_o (res_vld),
    .res_o     (res_d)
  );

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_acc) begin
      item_vld_d = 1'b1;
    end else if (fire) begin
      item_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = res_vld;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frh_q      <= 1'b0;
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      st_q       <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_wr) begin
        frh_q        <= first_row_is_header_i;
        st_q.in_header <= first_row_is_header_i;
      end else if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= command_i;
      char_q <= text_byte_i;
    end
    if (fire && res_vld) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = res_q.kind;
  assign content_byte_o  = res_q.content;
  assign cell_type_o     = res_q.cell_type;
  assign ends_row_o      = res_q.ends_row;
  assign integer_value_o = res_q.value;

  `ASSERT_CLK(a_byte_untyped,
              out_valid_o && (kind_o == KIND_BYTE) |->
                (cell_type_o == CELL_EMPTY) && !ends_row_o && (integer_value_o == 64'sd0),
              "content beat carries field data")
  `ASSERT_CLK(a_row_closes,
              out_valid_o && (kind_o == KIND_ROW) |-> ends_row_o && (cell_type_o == CELL_EMPTY),
              "row end beat malformed")
  `ASSERT_CLK(a_value_int_only,
              out_valid_o && (integer_value_o != 64'sd0) |-> (cell_type_o == CELL_INT),
              "value on a non-integer cell")
  `ASSERT_CLK(a_cfg_loads_hdr,
              cfg_wr |=> (st_q.in_header == $past(first_row_is_header_i)) &&
                (frh_q == $past(first_row_is_header_i)),
              "header flag not loaded by config write")
  `ASSERT_ALWAYS(a_stall_needs_item, !item_vld_q |-> !in_stall_o,
                 "input stalled with empty input register")

endmodule

/* sim/csv_field_tokenizer_typer_checker.sv */
// Watches the CSV tokenizer's channels, predicts its tokens and compares them
module csv_field_tokenizer_typer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        header_mode_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        command_i,
  input  logic [7:0]  text_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  content_byte_i,
  input  logic [2:0]  cell_type_i,
  input  logic        ends_row_i,
  input  logic [63:0] integer_value_i,
  output int          fail_count_o,
  output int          pending_o
);
  import csvt_pkg::*;

  res_t expected_tokens[$];
  res_t want;
  int   fails = 0;

  logic        hdr_cfg, hdr_row;
  logic        quoted, quote_wait, skip_ws, fld_open, row_open;
  logic        is_text, got_digit, got_point, neg;
  logic [1:0]  signs;
  phase_e      phase;
  logic [63:0] mag;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic numeral_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_cell();
    quoted = 1'b0; quote_wait = 1'b0; fld_open = 1'b0; is_text = 1'b0;
    got_digit = 1'b0; signs = 2'd0; got_point = 1'b0;
    phase = PH_LEAD; neg = 1'b0; mag = 64'd0;
  endtask

  task automatic push_token(input kind_e k, input logic [7:0] b, input cell_e t,
                            input logic ends, input logic [63:0] v);
    res_t r;
    r.kind = k;
    r.content = b;
    r.cell_type = t;
    r.ends_row = ends;
    r.value = v;
    expected_tokens.push_back(r);
  endtask

  task automatic add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CH_ZERO);
    if (mag > (ACC_CAP - d) / 64'd10) mag = ACC_CAP;
    else mag = mag * 64'd10 + d;
  endtask

  task automatic feed_number(input logic [7:0] c);
    case (phase)
      PH_LEAD: begin
        if (blank_char(c)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          phase = PH_DIGITS;
        end else if (numeral_char(c)) begin
          add_digit(c);
          phase = PH_DIGITS;
        end else begin
          phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (numeral_char(c)) add_digit(c);
        else phase = PH_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic classify_char(input logic [7:0] c);
    if (numeral_char(c)) got_digit = 1'b1;
    else if (c == CH_POINT) got_point = 1'b1;
    else if (c == CH_PLUS || c == CH_MINUS) begin
      if (got_digit) is_text = 1'b1;
      else if (signs < 2'd2) signs = signs + 2'd1;
    end else if (!blank_char(c)) is_text = 1'b1;
  endtask

  task automatic close_field(input logic ends);
    cell_e       t;
    logic [63:0] v;
    v = 64'd0;
    if (hdr_row) t = CELL_HEADER;
    else if (!fld_open) t = CELL_EMPTY;
    else if (is_text || signs > 2'd1 || !got_digit) t = CELL_TEXT;
    else if (got_point) t = CELL_DEC;
    else t = CELL_INT;
    if (t == CELL_INT) begin
      if (neg) v = 64'd0 - mag;
      else v = (mag >= ACC_CAP) ? ACC_CAP - 64'd1 : mag;
    end
    push_token(KIND_FIELD, 8'h00, t, ends, v);
    clear_cell();
    if (ends) begin
      row_open = 1'b0;
      hdr_row = 1'b0;
      skip_ws = 1'b1;
    end else begin
      row_open = 1'b1;
    end
  endtask

  task automatic tokenize_beat(input logic cmd, input logic [7:0] c);
    if (cmd == CMD_END) begin
      if (fld_open || (hdr_row && row_open)) close_field(1'b1);
      else if (row_open) push_token(KIND_ROW, 8'h00, CELL_EMPTY, 1'b1, 64'd0);
      clear_cell();
      row_open = 1'b0;
      skip_ws = 1'b0;
      hdr_row = hdr_cfg;
      return;
    end
    if (quote_wait) begin
      quote_wait = 1'b0;
      if (c == CH_QUOTE) begin
        feed_number(c);
        push_token(KIND_BYTE, c, CELL_EMPTY, 1'b0, 64'd0);
        return;
      end
      quoted = !quoted;
    end else if (skip_ws) begin
      if (blank_char(c)) return;
      skip_ws = 1'b0;
    end
    if (!quoted) begin
      if (c == CH_COMMA) begin
        close_field(1'b0);
        return;
      end
      if (c == CH_LF || c == CH_CR) begin
        if (fld_open || hdr_row) begin
          close_field(1'b1);
        end else begin
          push_token(KIND_ROW, 8'h00, CELL_EMPTY, 1'b1, 64'd0);
          clear_cell();
          row_open = 1'b0;
          skip_ws = 1'b1;
        end
        return;
      end
    end
    fld_open = 1'b1;
    if (c == CH_QUOTE) begin
      quote_wait = 1'b1;
      is_text = 1'b1;
      feed_number(c);
      return;
    end
    classify_char(c);
    feed_number(c);
    push_token(KIND_BYTE, c, CELL_EMPTY, 1'b0, 64'd0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cfg = 1'b0;
      hdr_row = 1'b0;
      row_open = 1'b0;
      skip_ws = 1'b0;
      clear_cell();
      expected_tokens.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected beat: kind %0d, byte %0d, cell %0d", kind_i, content_byte_i,
                 cell_type_i);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            fails++;
          end
          if (content_byte_i !== want.content) begin
            $error("content_byte: expected %0d, got %0d", want.content, content_byte_i);
            fails++;
          end
          if (cell_type_i !== want.cell_type) begin
            $error("cell_type: expected %0d, got %0d", want.cell_type, cell_type_i);
            fails++;
          end
          if (ends_row_i !== want.ends_row) begin
            $error("ends_row: expected %0d, got %0d", want.ends_row, ends_row_i);
            fails++;
          end
          if (integer_value_i !== want.value) begin
            $error("integer_value: expected %0d, got %0d", $signed(want.value),
                   $signed(integer_value_i));
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        hdr_cfg = header_mode_i;
        hdr_row = header_mode_i;
      end
      if (in_valid_i && !in_stall_i) tokenize_beat(command_i, text_byte_i);
    end
    pending_o = expected_tokens.size();
    fail_count_o = fails;
  end

endmodule

/* sim/csv_field_tokenizer_typer_tb.sv */
// Stimulus and verdict for the CSV tokenizer, with the checker beside it
module csv_field_tokenizer_typer_tb;
  import csvt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 285;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        first_row_is_header_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [7:0]  text_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  content_byte_o;
  logic [2:0]  cell_type_o;
  logic        ends_row_o;
  logic signed [63:0] integer_value_o;

  int fail_count;
  int pending;
  int beats_sent = 0;
  int quiet_cycles = 0;
  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;

  csv_field_tokenizer_typer dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .first_row_is_header_i (first_row_is_header_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .command_i             (command_i),
    .text_byte_i           (text_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .kind_o                (kind_o),
    .content_byte_o        (content_byte_o),
    .cell_type_o           (cell_type_o),
    .ends_row_o            (ends_row_o),
    .integer_value_o       (integer_value_o)
  );

  csv_field_tokenizer_typer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .header_mode_i   (first_row_is_header_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .command_i       (command_i),
    .text_byte_i     (text_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_i          (kind_o),
    .content_byte_i  (content_byte_o),
    .cell_type_i     (cell_type_o),
    .ends_row_i      (ends_row_o),
    .integer_value_i (integer_value_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // token sink: random hold-off before each beat while out_idle_on is set
  initial begin
    int hold;
    out_stall_i = 1'b0;
    forever begin
      hold = out_idle_on ? $urandom_range(0, 15) : 0;
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  task automatic send_beat(input logic cmd, input logic [7:0] b);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    text_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(1'b0, b);
  endtask

  task automatic send_end();
    send_beat(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic send_letter();
    send_byte(8'(8'h61 + $urandom_range(0, 25)));
  endtask

  task automatic maybe_sign();
    if ($urandom_range(0, 2) == 0) send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
  endtask

  task automatic pad_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 4))
        0: send_byte(CH_TAB);
        1: send_byte(8'h0B);
        2: send_byte(8'h0C);
        default: send_byte(CH_SPACE);
      endcase
    end
  endtask

  task automatic emit_field();
    int n;
    case ($urandom_range(0, 9))
      0: ;
      1, 2: begin
        pad_blanks();
        maybe_sign();
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6);
        send_digits(n);
        pad_blanks();
      end
      3: begin
        maybe_sign();
        send_digits($urandom_range(0, 4));
        send_byte(CH_POINT);
        send_digits($urandom_range(0, 4));
      end
      4: repeat ($urandom_range(1, 5)) send_letter();
      5: begin
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: put_text("\"\"");
            1: send_byte(CH_COMMA);
            2: send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
            3: send_digits(1);
            default: send_letter();
          endcase
        end
        send_byte(CH_QUOTE);
      end
      6: repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 4))
          0: send_byte(CH_PLUS);
          1: send_byte(CH_MINUS);
          2: send_byte(CH_POINT);
          3: send_byte(CH_SPACE);
          default: send_digits(1);
        endcase
      end
      7: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      8: begin
        send_digits(1);
        send_byte(CH_QUOTE);
        send_letter();
        send_byte(CH_QUOTE);
      end
      default: begin
        if ($urandom_range(0, 1)) send_byte(CH_MINUS);
        repeat ($urandom_range(1, 3)) send_byte(CH_ZERO);
        send_digits($urandom_range(0, 2));
      end
    endcase
  endtask

  task automatic emit_record();
    int fields;
    fields = $urandom_range(1, 4);
    for (int i = 0; i < fields; i++) begin
      if (i > 0) send_byte(CH_COMMA);
      emit_field();
    end
    case ($urandom_range(0, 5))
      0, 1: send_byte(CH_LF);
      2: send_byte(CH_CR);
      3: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      4: begin
        send_byte(CH_COMMA);
        send_byte(CH_LF);
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      pad_blanks();
      if ($urandom_range(0, 1)) send_byte(CH_LF);
    end
  endtask

  task automatic emit_document();
    if ($urandom_range(0, 2) == 0) in_idle_on = !in_idle_on;
    if ($urandom_range(0, 2) == 0) out_idle_on = !out_idle_on;
    repeat ($urandom_range(1, 4)) emit_record();
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        emit_field();
        send_byte(CH_COMMA);
        send_end();
      end
      default: send_end();
    endcase
  endtask

  // hold the sender until every token is out and the pipe has emptied
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_header_mode(input logic v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    first_row_is_header_i <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    first_row_is_header_i = 1'b0;
    in_valid_i = 1'b0;
    command_i = 1'b0;
    text_byte_i = 8'h00;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    put_text("1,\"a\"\"\",\n -3.5\r");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_end();
    put_text("7,");
    send_end();

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      set_header_mode(p % 2 == 0);
      in_idle_on = 1'($urandom_range(0, 1));
      out_idle_on = 1'($urandom_range(0, 1));
      while (beats_sent < (p + 1) * BEATS_PER_PHASE) emit_document();
    end
    send_end();

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
